>>> hdl/rk4vdi_pkg.sv
// ----------------------------------------------------------------------------
// rk4vdi_pkg
// Shared types, constants and the microcode table of the RK4 drag integrator.
// ----------------------------------------------------------------------------
package rk4vdi_pkg;

  // fixed field widths
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned DT_W    = 17;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned APB_W   = 32;
  localparam int unsigned OPB_W   = WORD_W + 1;
  localparam int unsigned PROD_W  = WORD_W + OPB_W;
  localparam int unsigned PAIR_W  = WORD_W + 1;
  localparam int unsigned SUM_W   = WORD_W + 3;
  localparam int unsigned PC_W    = 5;

  // divide-by-six unit: halve, then divide by three one byte per cycle
  localparam int unsigned DIV_DIGIT = 8;
  localparam int unsigned DIV_STEPS = (SUM_W - 1 + DIV_DIGIT - 1) / DIV_DIGIT;
  localparam int unsigned DIV_W     = DIV_STEPS * DIV_DIGIT;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 2);

  // register reset values
  localparam logic signed [WORD_W-1:0] DRAG_RESET = '0;
  localparam logic [DT_W-1:0]          DT_RESET   = DT_W'(1092);

  // saturation limits
  localparam logic signed [WORD_W-1:0] Q_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] Q_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  // register map
  typedef enum logic {
    REG_DRAG = 1'b0,
    REG_DT   = 1'b1
  } reg_e;

  // item commands
  typedef enum logic [CMD_W-1:0] {
    CMD_STEP     = 2'd0,
    CMD_IMPULSE  = 2'd1,
    CMD_LOAD_POS = 2'd2,
    CMD_LOAD_VEL = 2'd3
  } cmd_e;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_MUL,
    OP_WB,
    OP_SUM1,
    OP_SUM2,
    OP_DIVGO,
    OP_DIVWAIT,
    OP_AXIS,
    OP_DONE,
    OP_IMP,
    OP_LDP,
    OP_LDV
  } op_e;

  // multiplier operand a
  typedef enum logic [2:0] {
    SRC_V0,
    SRC_V1,
    SRC_V2,
    SRC_V3,
    SRC_A0,
    SRC_A1,
    SRC_A2,
    SRC_Q
  } src_e;

  // multiplier operand b
  typedef enum logic {
    MB_K,
    MB_DT
  } mulb_e;

  // write-back destination
  typedef enum logic [3:0] {
    DST_A0,
    DST_A1,
    DST_A2,
    DST_A3,
    DST_V1,
    DST_V2,
    DST_V3,
    DST_P,
    DST_V
  } dst_e;

  // addend for write-back
  typedef enum logic [1:0] {
    BASE_ZERO,
    BASE_V0,
    BASE_P
  } base_e;

  // sequencing condition
  typedef enum logic [2:0] {
    CD_NEXT,
    CD_JUMP,
    CD_AXIS0,
    CD_DIV,
    CD_END
  } cond_e;

  // sequencer state
  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

  // microcode word
  typedef struct packed {
    op_e             op;
    src_e            srca;
    mulb_e           mulb;
    logic            half;
    dst_e            dst;
    base_e           base;
    logic            acc;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ctl_t;

  // datapath status back to the sequencer
  typedef struct packed {
    logic axis;
    logic div_busy;
    logic div_done;
  } dp_stat_t;

  // clamp result
  typedef struct packed {
    logic                     ovf;
    logic signed [WORD_W-1:0] val;
  } clamp_t;

  // program entry points
  localparam logic [PC_W-1:0] UA_STEP = PC_W'(0);
  localparam logic [PC_W-1:0] UA_DONE = PC_W'(27);
  localparam logic [PC_W-1:0] UA_IMP  = PC_W'(28);
  localparam logic [PC_W-1:0] UA_LDP  = PC_W'(29);
  localparam logic [PC_W-1:0] UA_LDV  = PC_W'(30);

  // clamp a wide signed value to the word range
  function automatic clamp_t clamp_q(input logic signed [PROD_W-1:0] x);
    clamp_t r;
    logic   pos_ovf;
    logic   neg_ovf;
    pos_ovf = !x[PROD_W-1] && (|x[PROD_W-2:WORD_W-1]);
    neg_ovf = x[PROD_W-1] && !(&x[PROD_W-2:WORD_W-1]);
    r.ovf   = pos_ovf || neg_ovf;
    if (pos_ovf) begin
      r.val = Q_MAX;
    end else if (neg_ovf) begin
      r.val = Q_MIN;
    end else begin
      r.val = x[WORD_W-1:0];
    end
    return r;
  endfunction

  // build one microcode word
  function automatic ctl_t mk(input op_e op, input src_e srca, input mulb_e mulb,
                              input logic half, input dst_e dst, input base_e base,
                              input logic acc, input cond_e cond,
                              input logic [PC_W-1:0] target);
    ctl_t w;
    w.op     = op;
    w.srca   = srca;
    w.mulb   = mulb;
    w.half   = half;
    w.dst    = dst;
    w.base   = base;
    w.acc    = acc;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // entry point for each command
  function automatic logic [PC_W-1:0] ucode_entry(input cmd_e cmd);
    logic [PC_W-1:0] a;
    unique case (cmd)
      CMD_STEP:     a = UA_STEP;
      CMD_IMPULSE:  a = UA_IMP;
      CMD_LOAD_POS: a = UA_LDP;
      CMD_LOAD_VEL: a = UA_LDV;
      default:      a = UA_DONE;
    endcase
    return a;
  endfunction

  // control store: one rk4 axis, then the other, then deliver; then the single-word commands
  function automatic ctl_t ucode_rom(input logic [PC_W-1:0] pc);
    ctl_t w;
    unique case (pc)
      // a0 = k*v0, v1 = v0 + a0*dt/2
      5'd0:  w = mk(OP_MUL,  SRC_V0, MB_K,  1'b0, DST_A0, BASE_ZERO, 1'b0, CD_NEXT, '0);
      5'd1:  w = mk(OP_WB,   SRC_V0, MB_K,  1'b0, DST_A0, BASE_ZERO, 1'b0, CD_NEXT, '0);
      5'd2:  w = mk(OP_MUL,  SRC_A0, MB_DT, 1'b0, DST_A0, BASE_ZERO, 1'b0, CD_NEXT, '0);
      5'd3:  w = mk(OP_WB,   SRC_V0, MB_K,  1'b1, DST_V1, BASE_V0,   1'b0, CD_NEXT, '0);
      // a1 = k*v1, v2 = v0 + a1*dt/2
      5'd4:  w = mk(OP_MUL,  SRC_V1, MB_K,  1'b0, DST_A0, BASE_ZERO, 1'b0, CD_NEXT, '0);
      5'd5:  w = mk(OP_WB,   SRC_V0, MB_K,  1'b0, DST_A1, BASE_ZERO, 1'b0, CD_NEXT, '0);
      5'd6:  w = mk(OP_MUL,  SRC_A1, MB_DT, 1'b0, DST_A0, BASE_ZERO, 1'b0, CD_NEXT, '0);
      5'd7:  w = mk(OP_WB,   SRC_V0, MB_K,  1'b1, DST_V2, BASE_V0,   1'b0, CD_NEXT, '0);
      // a2 = k*v2, v3 = v0 + a2*dt
      5'd8:  w = mk(OP_MUL,  SRC_V2, MB_K,  1'b0, DST_A0, BASE_ZERO, 1'b0, CD_NEXT, '0);
      5'd9:  w = mk(OP_WB,   SRC_V0, MB_K,  1'b0, DST_A2, BASE_ZERO, 1'b0, CD_NEXT, '0);
      5'd10: w = mk(OP_MUL,  SRC_A2, MB_DT, 1'b0, DST_A0, BASE_ZERO, 1'b0, CD_NEXT, '0);
      5'd11: w = mk(OP_WB,   SRC_V0, MB_K,  1'b0, DST_V3, BASE_V0,   1'b0, CD_NEXT, '0);
      // a3 = k*v3
      5'd12: w = mk(OP_MUL,  SRC_V3, MB_K,  1'b0, DST_A0, BASE_ZERO, 1'b0, CD_NEXT, '0);
      5'd13: w = mk(OP_WB,   SRC_V0, MB_K,  1'b0, DST_A3, BASE_ZERO, 1'b0, CD_NEXT, '0);
      // position update
      5'd14: w = mk(OP_SUM1, SRC_V0, MB_K,  1'b0, DST_A0, BASE_ZERO, 1'b0, CD_NEXT, '0);
      5'd15: w = mk(OP_SUM2, SRC_V0, MB_K,  1'b0, DST_A0, BASE_ZERO, 1'b0, CD_NEXT, '0);
      5'd16: w = mk(OP_DIVGO, SRC_V0, MB_K, 1'b0, DST_A0, BASE_ZERO, 1'b0, CD_NEXT, '0);
      5'd17: w = mk(OP_DIVWAIT, SRC_V0, MB_K, 1'b0, DST_A0, BASE_ZERO, 1'b0, CD_DIV, '0);
      5'd18: w = mk(OP_MUL,  SRC_Q,  MB_DT, 1'b0, DST_A0, BASE_ZERO, 1'b0, CD_NEXT, '0);
      5'd19: w = mk(OP_WB,   SRC_V0, MB_K,  1'b0, DST_P,  BASE_P,    1'b0, CD_NEXT, '0);
      // velocity update
      5'd20: w = mk(OP_SUM1, SRC_V0, MB_K,  1'b0, DST_A0, BASE_ZERO, 1'b1, CD_NEXT, '0);
      5'd21: w = mk(OP_SUM2, SRC_V0, MB_K,  1'b0, DST_A0, BASE_ZERO, 1'b1, CD_NEXT, '0);
      5'd22: w = mk(OP_DIVGO, SRC_V0, MB_K, 1'b0, DST_A0, BASE_ZERO, 1'b0, CD_NEXT, '0);
      5'd23: w = mk(OP_DIVWAIT, SRC_V0, MB_K, 1'b0, DST_A0, BASE_ZERO, 1'b0, CD_DIV, '0);
      5'd24: w = mk(OP_MUL,  SRC_Q,  MB_DT, 1'b0, DST_A0, BASE_ZERO, 1'b0, CD_NEXT, '0);
      5'd25: w = mk(OP_WB,   SRC_V0, MB_K,  1'b0, DST_V,  BASE_V0,   1'b0, CD_NEXT, '0);
      // second axis, then deliver
      5'd26: w = mk(OP_AXIS, SRC_V0, MB_K,  1'b0, DST_A0, BASE_ZERO, 1'b0, CD_AXIS0, UA_STEP);
      5'd27: w = mk(OP_DONE, SRC_V0, MB_K,  1'b0, DST_A0, BASE_ZERO, 1'b0, CD_END, '0);
      // single-word commands
      5'd28: w = mk(OP_IMP,  SRC_V0, MB_K,  1'b0, DST_A0, BASE_ZERO, 1'b0, CD_JUMP, UA_DONE);
      5'd29: w = mk(OP_LDP,  SRC_V0, MB_K,  1'b0, DST_A0, BASE_ZERO, 1'b0, CD_JUMP, UA_DONE);
      5'd30: w = mk(OP_LDV,  SRC_V0, MB_K,  1'b0, DST_A0, BASE_ZERO, 1'b0, CD_JUMP, UA_DONE);
      default: w = mk(OP_NOP, SRC_V0, MB_K, 1'b0, DST_A0, BASE_ZERO, 1'b0, CD_END, '0);
    endcase
    return w;
  endfunction

endpackage

>>> hdl/rk4vdi_item_if.sv
// ----------------------------------------------------------------------------
// rk4vdi_item_if
// Command channel: valid/ready handshake carrying one command item.
// ----------------------------------------------------------------------------
interface rk4vdi_item_if;
  import rk4vdi_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [WORD_W-1:0] value_x;
  logic signed [WORD_W-1:0] value_y;

  modport source (output valid, output cmd, output value_x, output value_y, input ready);
  modport sink   (input valid, input cmd, input value_x, input value_y, output ready);
endinterface

>>> hdl/rk4vdi_result_if.sv
// ----------------------------------------------------------------------------
// rk4vdi_result_if
// Result channel: valid/ready handshake carrying the body state after an item.
// ----------------------------------------------------------------------------
interface rk4vdi_result_if;
  import rk4vdi_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] pos_x_out;
  logic signed [WORD_W-1:0] pos_y_out;
  logic signed [WORD_W-1:0] vel_x_out;
  logic signed [WORD_W-1:0] vel_y_out;
  logic                     saturated;

  modport source (output valid, output pos_x_out, output pos_y_out, output vel_x_out,
                  output vel_y_out, output saturated, input ready);
  modport sink   (input valid, input pos_x_out, input pos_y_out, input vel_x_out,
                  input vel_y_out, input saturated, output ready);
endinterface

>>> hdl/rk4vdi_div6.sv
// ----------------------------------------------------------------------------
// rk4vdi_div6
// Floor division of the RK4 weighted sum by six, one byte of quotient a cycle.
// ----------------------------------------------------------------------------
module rk4vdi_div6 (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [rk4vdi_pkg::SUM_W-1:0]  dividend_i,
  output logic                                 busy_o,
  output logic                                 done_o,
  output logic signed [rk4vdi_pkg::WORD_W-1:0] quot_o
);
  import rk4vdi_pkg::*;

  localparam logic [2:0]           DIVISOR  = 3'd3;
  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] CNT_FIN  = DIV_CNT_W'(DIV_STEPS + 1);

  logic [DIV_CNT_W-1:0]     cnt_q, cnt_d;
  logic                     done_q, done_d;
  logic                     neg_q;
  logic [DIV_W-1:0]         work_q, work_d;
  logic [DIV_W-1:0]         quo_q, quo_d;
  logic [1:0]               rem_q, rem_d;
  logic signed [WORD_W-1:0] res_q;

  logic signed [SUM_W:0]    ext;
  logic signed [SUM_W:0]    mag;
  logic [DIV_DIGIT-1:0]     qdig;
  logic [2:0]               trial;
  logic [1:0]               rem;

  // magnitude with floor bias for negative sums: -((-s + 5) / 6)
  always_comb begin
    ext = {dividend_i[SUM_W-1], dividend_i};
    mag = dividend_i[SUM_W-1] ? ((SUM_W+1)'(5) - ext) : ext;
  end

  // restoring division by three over one byte
  always_comb begin
    rem  = rem_q;
    qdig = '0;
    for (int i = 0; i < DIV_DIGIT; i++) begin
      trial = {rem, work_q[DIV_W-1-i]};
      if (trial >= DIVISOR) begin
        rem                  = 2'(trial - DIVISOR);
        qdig[DIV_DIGIT-1-i]  = 1'b1;
      end else begin
        rem = trial[1:0];
      end
    end
    rem_d  = rem;
    quo_d  = {quo_q[DIV_W-DIV_DIGIT-1:0], qdig};
    work_d = {work_q[DIV_W-DIV_DIGIT-1:0], {DIV_DIGIT{1'b0}}};
  end

  // step counter: idle, byte steps, final sign fix
  always_comb begin
    cnt_d  = cnt_q;
    done_d = done_q;
    if (start_i) begin
      cnt_d  = DIV_CNT_W'(1);
      done_d = 1'b0;
    end else if (cnt_q == CNT_FIN) begin
      cnt_d  = '0;
      done_d = 1'b1;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // operand and quotient registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q  <= dividend_i[SUM_W-1];
      work_q <= DIV_W'(mag[SUM_W-1:1]);
      quo_q  <= '0;
      rem_q  <= '0;
    end else if (cnt_q != '0 && cnt_q <= CNT_LAST) begin
      work_q <= work_d;
      quo_q  <= quo_d;
      rem_q  <= rem_d;
    end
    if (cnt_q == CNT_FIN) begin
      res_q <= neg_q ? -quo_q[WORD_W-1:0] : quo_q[WORD_W-1:0];
    end
  end

  assign busy_o = (cnt_q != '0);
  assign done_o = done_q;
  assign quot_o = res_q;

endmodule

>>> hdl/rk4vdi_datapath.sv
// ----------------------------------------------------------------------------
// rk4vdi_datapath
// Body state, RK4 temporaries, shared multiplier and saturating write-back.
// ----------------------------------------------------------------------------
module rk4vdi_datapath #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [rk4vdi_pkg::WORD_W-1:0] value_x_i,
  input  logic signed [rk4vdi_pkg::WORD_W-1:0] value_y_i,
  input  logic signed [rk4vdi_pkg::WORD_W-1:0] drag_i,
  input  logic [rk4vdi_pkg::DT_W-1:0]          dt_i,
  input  logic                                 run_i,
  input  rk4vdi_pkg::ctl_t                     cw_i,
  output rk4vdi_pkg::dp_stat_t                 stat_o,
  output logic signed [rk4vdi_pkg::WORD_W-1:0] pos_x_o,
  output logic signed [rk4vdi_pkg::WORD_W-1:0] pos_y_o,
  output logic signed [rk4vdi_pkg::WORD_W-1:0] vel_x_o,
  output logic signed [rk4vdi_pkg::WORD_W-1:0] vel_y_o,
  output logic                                 sat_o
);
  import rk4vdi_pkg::*;

  // architectural state
  logic signed [WORD_W-1:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q;
  logic                     axis_q;
  logic                     sat_q;

  // operands of the current item
  logic signed [WORD_W-1:0] opx_q, opy_q;

  // rk4 temporaries
  logic signed [WORD_W-1:0] v1_q, v2_q, v3_q, a0_q, a1_q, a2_q, a3_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PAIR_W-1:0] pair_q;
  logic signed [SUM_W-1:0]  sum_q;

  logic signed [WORD_W-1:0] v0, pcur, opa, base_val, wb_val;
  logic signed [OPB_W-1:0]  opb;
  logic signed [PROD_W-1:0] shifted;
  logic signed [PAIR_W-1:0] base_sum, imp_x_sum, imp_y_sum;
  logic signed [PAIR_W-1:0] pair_d;
  logic signed [SUM_W-1:0]  sum_d, sum_b0, sum_b3;
  clamp_t                   c_prod, c_add, c_impx, c_impy;
  logic                     wb_ovf;
  logic                     op_on;

  logic                     div_busy, div_done;
  logic signed [WORD_W-1:0] div_q;

  assign op_on = run_i;

  // current axis
  assign v0   = axis_q ? vel_y_q : vel_x_q;
  assign pcur = axis_q ? pos_y_q : pos_x_q;

  // multiplier operands
  always_comb begin
    unique case (cw_i.srca)
      SRC_V0:  opa = v0;
      SRC_V1:  opa = v1_q;
      SRC_V2:  opa = v2_q;
      SRC_V3:  opa = v3_q;
      SRC_A0:  opa = a0_q;
      SRC_A1:  opa = a1_q;
      SRC_A2:  opa = a2_q;
      SRC_Q:   opa = div_q;
      default: opa = v0;
    endcase
    opb = (cw_i.mulb == MB_DT) ? $signed({{(OPB_W-DT_W){1'b0}}, dt_i})
                               : $signed({drag_i[WORD_W-1], drag_i});
  end

  // write-back: floor shift, clamp, optional add, clamp
  always_comb begin
    shifted = cw_i.half ? (prod_q >>> (FRAC_BITS + 1)) : (prod_q >>> FRAC_BITS);
    c_prod  = clamp_q(shifted);
    unique case (cw_i.base)
      BASE_V0:   base_val = v0;
      BASE_P:    base_val = pcur;
      default:   base_val = '0;
    endcase
    base_sum = $signed({base_val[WORD_W-1], base_val})
             + $signed({c_prod.val[WORD_W-1], c_prod.val});
    c_add    = clamp_q({{(PROD_W-PAIR_W){base_sum[PAIR_W-1]}}, base_sum});
    wb_val   = c_add.val;
    wb_ovf   = c_prod.ovf || c_add.ovf;
  end

  // impulse adds
  always_comb begin
    imp_x_sum = $signed({vel_x_q[WORD_W-1], vel_x_q}) + $signed({opx_q[WORD_W-1], opx_q});
    imp_y_sum = $signed({vel_y_q[WORD_W-1], vel_y_q}) + $signed({opy_q[WORD_W-1], opy_q});
    c_impx    = clamp_q({{(PROD_W-PAIR_W){imp_x_sum[PAIR_W-1]}}, imp_x_sum});
    c_impy    = clamp_q({{(PROD_W-PAIR_W){imp_y_sum[PAIR_W-1]}}, imp_y_sum});
  end

  // weighted sum b0 + 2*(b1 + b2) + b3
  always_comb begin
    if (cw_i.acc) begin
      pair_d = $signed({a1_q[WORD_W-1], a1_q}) + $signed({a2_q[WORD_W-1], a2_q});
      sum_b0 = $signed({{(SUM_W-WORD_W){a0_q[WORD_W-1]}}, a0_q});
      sum_b3 = $signed({{(SUM_W-WORD_W){a3_q[WORD_W-1]}}, a3_q});
    end else begin
      pair_d = $signed({v1_q[WORD_W-1], v1_q}) + $signed({v2_q[WORD_W-1], v2_q});
      sum_b0 = $signed({{(SUM_W-WORD_W){v0[WORD_W-1]}}, v0});
      sum_b3 = $signed({{(SUM_W-WORD_W){v3_q[WORD_W-1]}}, v3_q});
    end
    sum_d = sum_b0 + sum_b3
          + $signed({{(SUM_W-PAIR_W-1){pair_q[PAIR_W-1]}}, pair_q, 1'b0});
  end

  // control state: axis select and clip flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= 1'b0;
      sat_q  <= 1'b0;
    end else if (start_i) begin
      axis_q <= 1'b0;
      sat_q  <= 1'b0;
    end else if (op_on) begin
      if (cw_i.op == OP_AXIS) begin
        axis_q <= ~axis_q;
      end
      if (cw_i.op == OP_WB) begin
        sat_q <= sat_q | wb_ovf;
      end else if (cw_i.op == OP_IMP) begin
        sat_q <= sat_q | c_impx.ovf | c_impy.ovf;
      end
    end
  end

  // body state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      vel_x_q <= '0;
      vel_y_q <= '0;
    end else if (op_on) begin
      unique case (cw_i.op)
        OP_WB: begin
          if (cw_i.dst == DST_P) begin
            if (axis_q) pos_y_q <= wb_val;
            else        pos_x_q <= wb_val;
          end else if (cw_i.dst == DST_V) begin
            if (axis_q) vel_y_q <= wb_val;
            else        vel_x_q <= wb_val;
          end
        end
        OP_IMP: begin
          vel_x_q <= c_impx.val;
          vel_y_q <= c_impy.val;
        end
        OP_LDP: begin
          pos_x_q <= opx_q;
          pos_y_q <= opy_q;
        end
        OP_LDV: begin
          vel_x_q <= opx_q;
          vel_y_q <= opy_q;
        end
        default: begin
        end
      endcase
    end
  end

  // item operands
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      opx_q <= value_x_i;
      opy_q <= value_y_i;
    end
  end

  // temporaries, product and sums
  always_ff @(posedge clk_i) begin
    if (op_on) begin
      if (cw_i.op == OP_MUL) begin
        prod_q <= PROD_W'(opa * opb);
      end
      if (cw_i.op == OP_SUM1) begin
        pair_q <= pair_d;
      end
      if (cw_i.op == OP_SUM2) begin
        sum_q <= sum_d;
      end
      if (cw_i.op == OP_WB) begin
        unique case (cw_i.dst)
          DST_A0:  a0_q <= wb_val;
          DST_A1:  a1_q <= wb_val;
          DST_A2:  a2_q <= wb_val;
          DST_A3:  a3_q <= wb_val;
          DST_V1:  v1_q <= wb_val;
          DST_V2:  v2_q <= wb_val;
          DST_V3:  v3_q <= wb_val;
          default: begin
          end
        endcase
      end
    end
  end

  // divide-by-six unit
  rk4vdi_div6 u_div6 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (op_on && cw_i.op == OP_DIVGO),
    .dividend_i (sum_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  assign stat_o.axis     = axis_q;
  assign stat_o.div_busy = div_busy;
  assign stat_o.div_done = div_done;

  assign pos_x_o = pos_x_q;
  assign pos_y_o = pos_y_q;
  assign vel_x_o = vel_x_q;
  assign vel_y_o = vel_y_q;
  assign sat_o   = sat_q;

endmodule

>>> hdl/rk4vdi_seq.sv
// ----------------------------------------------------------------------------
// rk4vdi_seq
// Microcode sequencer: step counter over the control store with jumps.
// ----------------------------------------------------------------------------
module rk4vdi_seq (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [rk4vdi_pkg::CMD_W-1:0]       cmd_i,
  input  rk4vdi_pkg::dp_stat_t               stat_i,
  input  logic                               out_free_i,
  output logic                               run_o,
  output rk4vdi_pkg::ctl_t                   cw_o
);
  import rk4vdi_pkg::*;

  seq_state_e      state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d;
  ctl_t            cw;

  // control store read
  assign cw = ucode_rom(pc_q);

  // next state and step address
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    unique case (state_q)
      SEQ_IDLE: begin
        if (start_i) begin
          state_d = SEQ_RUN;
          pc_d    = ucode_entry(cmd_e'(cmd_i));
        end
      end
      SEQ_RUN: begin
        unique case (cw.cond)
          CD_NEXT:  pc_d = pc_q + PC_W'(1);
          CD_JUMP:  pc_d = cw.target;
          CD_AXIS0: pc_d = stat_i.axis ? (pc_q + PC_W'(1)) : cw.target;
          CD_DIV:   pc_d = stat_i.div_done ? (pc_q + PC_W'(1)) : pc_q;
          CD_END: begin
            if (out_free_i) begin
              state_d = SEQ_IDLE;
            end
          end
          default:  state_d = SEQ_IDLE;
        endcase
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      pc_q    <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

  assign run_o = (state_q == SEQ_RUN);
  assign cw_o  = cw;

endmodule

>>> hdl/rk4_velocity_drag_integrator_unit.sv
// ----------------------------------------------------------------------------
// rk4_velocity_drag_integrator_unit
// 2D body integrator: RK4 step with velocity drag, impulse and state loads.
// ----------------------------------------------------------------------------
// Keeps a body's position and velocity in signed fixed point with FRAC_BITS
// fraction bits and returns all four after every command item. One item is
// worked at a time; the next item is taken as soon as the previous result has
// been moved into the output register, even if it has not yet been taken. A
// step command runs each axis through the microcode around one shared 32x33
// multiplier plus two divide-by-six passes (one quotient byte per cycle),
// then delivers the result. Impulse and load commands run a single microcode
// word before delivery. The configuration registers (drag coefficient at 0x0,
// time step at 0x4) are to be written over APB only while no item is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module rk4_velocity_drag_integrator_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rk4vdi_pkg::ADDR_W-1:0]       paddr,
  input  logic [rk4vdi_pkg::APB_W-1:0]        pwdata,
  output logic [rk4vdi_pkg::APB_W-1:0]        prdata,
  output logic                                pready,
  rk4vdi_item_if.sink                         item_i,
  rk4vdi_result_if.source                     result_o
);
  import rk4vdi_pkg::*;

  logic signed [WORD_W-1:0] drag_q;
  logic [DT_W-1:0]          dt_q;

  logic                     cfg_wr;
  reg_e                     cfg_reg;

  logic                     seq_run;
  ctl_t                     cw;
  dp_stat_t                 dp_stat;
  logic                     start;
  logic                     out_free;
  logic                     out_load;

  logic signed [WORD_W-1:0] pos_x, pos_y, vel_x, vel_y;
  logic                     sat;

  logic                     out_valid_q, out_valid_d;
  logic signed [WORD_W-1:0] res_pos_x_q, res_pos_y_q, res_vel_x_q, res_vel_y_q;
  logic                     res_sat_q;

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_reg = reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drag_q <= DRAG_RESET;
      dt_q   <= DT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_reg)
        REG_DRAG: drag_q <= pwdata[WORD_W-1:0];
        REG_DT:   dt_q   <= pwdata[DT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg)
      REG_DRAG: prdata = drag_q;
      REG_DT:   prdata = {{(APB_W-DT_W){1'b0}}, dt_q};
      default:  prdata = '0;
    endcase
  end

  // command transfer
  assign item_i.ready = !seq_run;
  assign start        = item_i.valid && !seq_run;

  // result slot
  assign out_free = !out_valid_q || result_o.ready;
  assign out_load = seq_run && (cw.op == OP_DONE) && out_free;

  rk4vdi_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .cmd_i      (item_i.cmd),
    .stat_i     (dp_stat),
    .out_free_i (out_free),
    .run_o      (seq_run),
    .cw_o       (cw)
  );

  rk4vdi_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .value_x_i (item_i.value_x),
    .value_y_i (item_i.value_y),
    .drag_i    (drag_q),
    .dt_i      (dt_q),
    .run_i     (seq_run),
    .cw_i      (cw),
    .stat_o    (dp_stat),
    .pos_x_o   (pos_x),
    .pos_y_o   (pos_y),
    .vel_x_o   (vel_x),
    .vel_y_o   (vel_y),
    .sat_o     (sat)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_pos_x_q <= pos_x;
      res_pos_y_q <= pos_y;
      res_vel_x_q <= vel_x;
      res_vel_y_q <= vel_y;
      res_sat_q   <= sat;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.pos_x_out = res_pos_x_q;
  assign result_o.pos_y_out = res_pos_y_q;
  assign result_o.vel_x_out = res_vel_x_q;
  assign result_o.vel_y_out = res_vel_y_q;
  assign result_o.saturated = res_sat_q;

`ifndef SYNTHESIS
  // a transfer starts the program on the next cycle
  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> seq_run)
    else $error("sequencer not running after command transfer");

  // divide wait only follows a started division
  a_div_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_run && cw.op == OP_DIVWAIT) |-> (dp_stat.div_busy || dp_stat.div_done))
    else $error("waiting on divider that was never started");

  // every program leaves the x axis selected
  a_idle_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seq_run |-> !dp_stat.axis)
    else $error("axis select left on y while idle");
`endif

endmodule

>>> test/rk4_velocity_drag_integrator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rk4_velocity_drag_integrator_unit_tb
// Self-checking bench for the fixed-point RK4 body integrator with drag.
// ----------------------------------------------------------------------------
// A queue of command items feeds a clocked driver; a clocked monitor checks
// every returned state against a Q16.16 RK4 prediction kept in the bench.
// A directed opening hits extreme operands, clipping on impulse and step,
// a time step above one and a time step of zero. Random phases then run
// under several drag / time step settings, with random gaps on either side, both or neither,
// one long stall of the result side and full drains between phases.
// ----------------------------------------------------------------------------
module rk4_velocity_drag_integrator_unit_tb;
  import rk4vdi_pkg::*;

  localparam int unsigned FRAC            = 16;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned ITEMS_PER_PHASE = 200;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned DRAIN_CYCLES    = 100;
  localparam int unsigned HOLD_OFF_AT     = 400;
  localparam int unsigned HOLD_OFF_CYCLES = 500;
  localparam int unsigned MAX_GAP         = 13;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam longint      WORD_MAX        = longint'(Q_MAX);
  localparam longint      WORD_MIN        = longint'(Q_MIN);
  localparam realtime     RUN_LIMIT_NS    = 4_000_000;

  // one command item and one returned body state
  typedef struct packed {
    cmd_e                     cmd;
    logic signed [WORD_W-1:0] value_x;
    logic signed [WORD_W-1:0] value_y;
  } body_cmd_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] pos_x;
    logic signed [WORD_W-1:0] pos_y;
    logic signed [WORD_W-1:0] vel_x;
    logic signed [WORD_W-1:0] vel_y;
    logic                     saturated;
  } body_report_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [APB_W-1:0]  pwdata;
  logic [APB_W-1:0]  prdata;
  logic              pready;

  rk4vdi_item_if   item_bus ();
  rk4vdi_result_if result_bus ();

  rk4_velocity_drag_integrator_unit #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .item_i  (item_bus),
    .result_o(result_bus)
  );

  always #2 clk_i = ~clk_i;

  // bench-side body state and register copies
  longint body_px, body_py, body_vx, body_vy;
  longint drag_k, step_dt;
  bit     clip_seen;

  body_cmd_t    queued_cmds[$];
  body_report_t due_reports[$];
  body_cmd_t    offered;

  bit          sender_gaps_on;
  bit          sink_gaps_on;
  int unsigned send_gap;
  int unsigned sink_wait;
  int unsigned items_taken;
  int unsigned hold_off_left;
  bit          hold_off_used;
  int unsigned cmd_count[4];
  int unsigned reports_checked;
  int unsigned reg_writes;
  int unsigned fail_count;

  // ---------------------------------------------------------------- prediction

  function automatic longint clip_word(input longint x);
    if (x > WORD_MAX) begin
      clip_seen = 1'b1;
      return WORD_MAX;
    end
    if (x < WORD_MIN) begin
      clip_seen = 1'b1;
      return WORD_MIN;
    end
    return x;
  endfunction

  // exact product, floor shift, then clip
  function automatic longint scaled_product(input longint a, input longint b,
                                            input int unsigned sh);
    return clip_word((a * b) >>> sh);
  endfunction

  function automatic longint div6_floor(input longint s);
    if (s >= 0) begin
      return s / 6;
    end
    return -((-s + 5) / 6);
  endfunction

  // one RK4 step on one axis, acceleration = k * velocity
  function automatic void rk4_axis_update(inout longint p, inout longint v);
    longint v0, a0, v1, a1, v2, a2, v3, a3, dp, dv;
    v0 = v;
    a0 = scaled_product(v0, drag_k, FRAC);
    v1 = clip_word(v0 + scaled_product(a0, step_dt, FRAC + 1));
    a1 = scaled_product(v1, drag_k, FRAC);
    v2 = clip_word(v0 + scaled_product(a1, step_dt, FRAC + 1));
    a2 = scaled_product(v2, drag_k, FRAC);
    v3 = clip_word(v0 + scaled_product(a2, step_dt, FRAC));
    a3 = scaled_product(v3, drag_k, FRAC);
    dp = div6_floor(v0 + 2 * (v1 + v2) + v3);
    dv = div6_floor(a0 + 2 * (a1 + a2) + a3);
    p  = clip_word(p + scaled_product(dp, step_dt, FRAC));
    v  = clip_word(v0 + scaled_product(dv, step_dt, FRAC));
  endfunction

  function automatic body_report_t advance_body(input body_cmd_t c);
    body_report_t r;
    clip_seen = 1'b0;
    case (c.cmd)
      CMD_STEP: begin
        rk4_axis_update(body_px, body_vx);
        rk4_axis_update(body_py, body_vy);
      end
      CMD_IMPULSE: begin
        body_vx = clip_word(body_vx + longint'($signed(c.value_x)));
        body_vy = clip_word(body_vy + longint'($signed(c.value_y)));
      end
      CMD_LOAD_POS: begin
        body_px = longint'($signed(c.value_x));
        body_py = longint'($signed(c.value_y));
      end
      default: begin
        body_vx = longint'($signed(c.value_x));
        body_vy = longint'($signed(c.value_y));
      end
    endcase
    r.pos_x     = body_px[WORD_W-1:0];
    r.pos_y     = body_py[WORD_W-1:0];
    r.vel_x     = body_vx[WORD_W-1:0];
    r.vel_y     = body_vy[WORD_W-1:0];
    r.saturated = clip_seen;
    return r;
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      item_bus.valid   <= 1'b0;
      item_bus.cmd     <= CMD_STEP;
      item_bus.value_x <= '0;
      item_bus.value_y <= '0;
      send_gap = 0;
      items_taken <= 0;
    end else begin
      // transfer taken: predict the state it returns
      if (item_bus.valid && item_bus.ready) begin
        due_reports.push_back(advance_body(offered));
        cmd_count[offered.cmd]++;
        items_taken <= items_taken + 1;
      end
      if (item_bus.valid && !item_bus.ready) begin
        // keep offering the same item
      end else if (send_gap != 0) begin
        send_gap--;
        item_bus.valid <= 1'b0;
      end else if (queued_cmds.size() != 0) begin
        offered = queued_cmds.pop_front();
        item_bus.cmd     <= offered.cmd;
        item_bus.value_x <= offered.value_x;
        item_bus.value_y <= offered.value_y;
        item_bus.valid   <= 1'b1;
        send_gap = sender_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      end else begin
        item_bus.valid <= 1'b0;
      end
    end
  end

  // one long result-side stall, so the block backs up into its input
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_off_left <= 0;
      hold_off_used <= 1'b0;
    end else if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
    end else if (!hold_off_used && items_taken >= HOLD_OFF_AT) begin
      hold_off_left <= HOLD_OFF_CYCLES;
      hold_off_used <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- monitor

  function automatic void note_failure(input body_report_t seen, input body_report_t want,
                                       input bit orphan);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      if (orphan) begin
        $display("[%0t] result with nothing pending: pos %h %h vel %h %h sat %b", $realtime,
                 seen.pos_x, seen.pos_y, seen.vel_x, seen.vel_y, seen.saturated);
      end else begin
        $display("[%0t] state mismatch", $realtime);
        $display("  got      pos %h %h vel %h %h sat %b",
                 seen.pos_x, seen.pos_y, seen.vel_x, seen.vel_y, seen.saturated);
        $display("  expected pos %h %h vel %h %h sat %b",
                 want.pos_x, want.pos_y, want.vel_x, want.vel_y, want.saturated);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    body_report_t seen;
    body_report_t want;
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        seen.pos_x     = result_bus.pos_x_out;
        seen.pos_y     = result_bus.pos_y_out;
        seen.vel_x     = result_bus.vel_x_out;
        seen.vel_y     = result_bus.vel_y_out;
        seen.saturated = result_bus.saturated;
        reports_checked++;
        if (due_reports.size() == 0) begin
          note_failure(seen, seen, 1'b1);
        end else begin
          want = due_reports.pop_front();
          if (seen.pos_x !== want.pos_x || seen.pos_y !== want.pos_y ||
              seen.vel_x !== want.vel_x || seen.vel_y !== want.vel_y ||
              seen.saturated !== want.saturated) begin
            note_failure(seen, want, 1'b0);
          end
        end
        sink_wait = sink_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      end else if (sink_wait != 0) begin
        sink_wait--;
      end
      result_bus.ready <= (sink_wait == 0) && (hold_off_left == 0);
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic void queue_item(input cmd_e c, input logic signed [WORD_W-1:0] x,
                                     input logic signed [WORD_W-1:0] y);
    body_cmd_t it;
    it.cmd     = c;
    it.value_x = x;
    it.value_y = y;
    queued_cmds.push_back(it);
  endfunction

  // operands: full range, a few units, extremes, or around zero
  function automatic logic signed [WORD_W-1:0] pick_operand();
    logic signed [WORD_W-1:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2: begin
        v = $urandom_range(0, 32'h0008_0000);
        v = v - 32'sh0004_0000;
      end
      3: begin
        case ($urandom_range(0, 4))
          0: v = Q_MAX;
          1: v = Q_MIN;
          2: v = '0;
          3: v = -32'sd1;
          default: v = 32'sd1;
        endcase
      end
      default: begin
        v = $urandom_range(0, 32'h00C8_0000);
        v = v - 32'sh0064_0000;
      end
    endcase
    return v;
  endfunction

  function automatic void queue_random_item();
    cmd_e c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: c = CMD_STEP;
      5, 6:          c = CMD_IMPULSE;
      7:             c = CMD_LOAD_POS;
      default:       c = CMD_LOAD_VEL;
    endcase
    queue_item(c, pick_operand(), pick_operand());
  endfunction

  // wait until nothing is queued, offered or outstanding
  task automatic settle();
    while (queued_cmds.size() != 0 || item_bus.valid || due_reports.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // apb write: setup cycle, then access cycle
  task automatic write_reg(input reg_e which, input logic [APB_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({which, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (which == REG_DRAG) begin
      drag_k = longint'($signed(data[WORD_W-1:0]));
    end else begin
      step_dt = longint'(data[DT_W-1:0]);
    end
    reg_writes++;
    @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [APB_W-1:0] k, input logic [APB_W-1:0] dt);
    settle();
    write_reg(REG_DRAG, k);
    write_reg(REG_DT, dt);
  endtask

  initial begin
    logic [APB_W-1:0] k_val;
    logic [APB_W-1:0] dt_val;
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    sender_gaps_on   = 1'b1;
    sink_gaps_on     = 1'b1;
    drag_k           = longint'($signed(DRAG_RESET));
    step_dt          = longint'(DT_RESET);
    body_px          = 0;
    body_py          = 0;
    body_vx          = 0;
    body_vy          = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: zero drag, time step about 1/60
    queue_item(CMD_STEP, '0, '0);
    queue_item(CMD_LOAD_POS, Q_MAX, Q_MIN);
    queue_item(CMD_LOAD_VEL, Q_MIN, Q_MAX);
    queue_item(CMD_STEP, '0, '0);
    queue_item(CMD_IMPULSE, -32'sd1, 32'sd1);
    queue_item(CMD_IMPULSE, Q_MAX, Q_MIN);
    queue_item(CMD_LOAD_POS, '0, '0);
    queue_item(CMD_LOAD_VEL, 32'sh0001_0000, -32'sh0001_0000);
    queue_item(CMD_STEP, '0, '0);

    // drag of minus one with the largest time step, well above one
    program_regs(32'hFFFF_0000, 32'd131071);
    queue_item(CMD_STEP, '0, '0);
    queue_item(CMD_STEP, '0, '0);
    queue_item(CMD_LOAD_VEL, Q_MAX, Q_MIN);
    queue_item(CMD_STEP, '0, '0);

    // zero time step: state stays, large drag still clips inside
    program_regs(Q_MAX, 32'd0);
    queue_item(CMD_LOAD_VEL, 32'sh4000_0000, -32'sh4000_0000);
    queue_item(CMD_STEP, '0, '0);
    queue_item(CMD_STEP, '0, '0);

    // unit time step, no drag, tiny velocities
    program_regs(32'd0, 32'd65536);
    queue_item(CMD_IMPULSE, '0, '0);
    queue_item(CMD_LOAD_VEL, 32'sd1, -32'sd1);
    queue_item(CMD_STEP, '0, '0);
    queue_item(CMD_STEP, '0, '0);

    // random phases, each under its own register setting and idling mix
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin k_val = 32'hFFFF_8000;        dt_val = 32'd1092;   end
        1: begin k_val = Q_MAX;                dt_val = 32'd65536;  end
        2: begin k_val = Q_MIN;                dt_val = 32'd131071; end
        3: begin
          k_val  = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
          dt_val = $urandom_range(0, 131071);
        end
        4: begin k_val = 32'h0001_0000;        dt_val = 32'd0;      end
        5: begin k_val = $urandom;             dt_val = $urandom_range(0, 131071); end
        6: begin k_val = 32'hFFFE_0000;        dt_val = 32'd65536;  end
        default: begin
          k_val  = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
          dt_val = 32'd1;
        end
      endcase
      program_regs(k_val, dt_val);
      sender_gaps_on = (ph % 4 == 0) || (ph % 4 == 2);
      sink_gaps_on   = (ph % 4 == 0) || (ph % 4 == 1);
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        queue_random_item();
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (due_reports.size() != 0) begin
      fail_count += due_reports.size();
      $display("%0d expected states never returned", due_reports.size());
    end

    $display("covered %0d steps, %0d impulses, %0d position loads, %0d velocity loads",
             cmd_count[CMD_STEP], cmd_count[CMD_IMPULSE], cmd_count[CMD_LOAD_POS],
             cmd_count[CMD_LOAD_VEL]);
    $display("%0d states checked over %0d register writes, %0d failures",
             reports_checked, reg_writes, fail_count);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> sim.f
hdl/rk4vdi_pkg.sv
hdl/rk4vdi_item_if.sv
hdl/rk4vdi_result_if.sv
hdl/rk4vdi_div6.sv
hdl/rk4vdi_datapath.sv
hdl/rk4vdi_seq.sv
hdl/rk4_velocity_drag_integrator_unit.sv
test/rk4_velocity_drag_integrator_unit_tb.sv
